### src/stc_pkg.sv
// Shared types and constants for the shell command tokenizer.
// No dependencies.
package stc_pkg;

   localparam int MaxRecs = 3;
   localparam int QDepth  = 4;
   localparam int QAw     = $clog2(QDepth);

   localparam logic [7:0] ChNul    = 8'h00;
   localparam logic [7:0] ChPipe   = 8'h7c;
   localparam logic [7:0] ChAmp    = 8'h26;
   localparam logic [7:0] ChSemi   = 8'h3b;
   localparam logic [7:0] ChLParen = 8'h28;
   localparam logic [7:0] ChRParen = 8'h29;
   localparam logic [7:0] ChLt     = 8'h3c;
   localparam logic [7:0] ChGt     = 8'h3e;
   localparam logic [7:0] ChDquote = 8'h22;
   localparam logic [7:0] ChSquote = 8'h27;
   localparam logic [7:0] ChSpace  = 8'h20;
   localparam logic [7:0] ChTab    = 8'h09;
   localparam logic [7:0] ChCr     = 8'h0d;
   localparam logic [7:0] ChTilde  = 8'h7e;

   typedef enum logic [2:0] {
      KIND_TEXT     = 3'd0,
      KIND_END_WORD = 3'd1,
      KIND_END_OP   = 3'd2,
      KIND_EOF      = 3'd3,
      KIND_ERROR    = 3'd4
   } kind_type;

   typedef enum logic [2:0] {
      MODE_IDLE    = 3'd0,
      MODE_OPHELD  = 3'd1,
      MODE_QSTR    = 3'd2,
      MODE_WORD    = 3'd3,
      MODE_WORDQ   = 3'd4,
      MODE_DISCARD = 3'd5
   } mode_type;

   typedef struct packed {
      kind_type   kind;
      logic [7:0] text_byte;
   } rec_type;

   typedef struct packed {
      logic [1:0]                count;
      rec_type [MaxRecs-1:0]     rec;
   } plan_type;

endpackage

### src/stc_front.sv
// Tokenizer front: accepts bytes, runs the lexer state, builds result plans.
// Depends on stc_pkg.
module stc_front (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_stall,
   input  logic [7:0]        req_ch,
   input  logic              q_full,
   output logic              q_push,
   output stc_pkg::plan_type q_plan
);
   import stc_pkg::*;

   mode_type   mode_ff, mode_in;
   logic       quote_single_ff, quote_single_in;
   logic [7:0] held_op_ff, held_op_in;

   logic       accept;

   logic       is_space, is_print, is_op, is_quote, is_dbl;
   logic [7:0] quote_ch;

   plan_type   st_plan;
   mode_type   st_mode;
   logic       st_quote_we, st_held_we;

   plan_type   plan;

   function automatic plan_type append(plan_type p, kind_type k, logic [7:0] b);
      plan_type r;
      r = p;
      if (p.count != 2'(MaxRecs)) begin
         r.rec[p.count].kind      = k;
         r.rec[p.count].text_byte = (k == KIND_TEXT) ? b : 8'h00;
         r.count                  = p.count + 2'd1;
      end
      return r;
   endfunction

   assign req_stall = q_full;
   assign accept    = req_valid && !q_full;

   assign is_space = (req_ch == ChSpace) || (req_ch >= ChTab && req_ch <= ChCr);
   assign is_print = (req_ch >= ChSpace) && (req_ch <= ChTilde);
   assign is_op    = (req_ch == ChPipe) || (req_ch == ChAmp) || (req_ch == ChSemi) ||
                     (req_ch == ChLParen) || (req_ch == ChRParen) ||
                     (req_ch == ChLt) || (req_ch == ChGt);
   assign is_dbl   = (req_ch == ChPipe) || (req_ch == ChAmp) || (req_ch == ChGt);
   assign is_quote = (req_ch == ChDquote) || (req_ch == ChSquote);
   assign quote_ch = quote_single_ff ? ChSquote : ChDquote;

   // start of a new token
   always_comb begin
      st_plan     = '0;
      st_mode     = MODE_IDLE;
      st_quote_we = 1'b0;
      st_held_we  = 1'b0;
      priority if (req_ch == ChNul) begin
         st_plan = append(st_plan, KIND_EOF, req_ch);
      end else if (is_space) begin
         st_mode = MODE_IDLE;
      end else if (is_op) begin
         st_plan = append(st_plan, KIND_TEXT, req_ch);
         if (is_dbl) begin
            st_held_we = 1'b1;
            st_mode    = MODE_OPHELD;
         end else begin
            st_plan = append(st_plan, KIND_END_OP, req_ch);
         end
      end else if (is_quote) begin
         st_quote_we = 1'b1;
         st_mode     = MODE_QSTR;
      end else if (is_print) begin
         st_plan = append(st_plan, KIND_TEXT, req_ch);
         st_mode = MODE_WORD;
      end else begin
         st_plan = append(st_plan, KIND_ERROR, req_ch);
         st_mode = MODE_DISCARD;
      end
   end

   always_comb begin
      plan            = '0;
      mode_in         = mode_ff;
      quote_single_in = quote_single_ff;
      held_op_in      = held_op_ff;
      unique case (mode_ff)
         MODE_OPHELD: begin
            if (req_ch == held_op_ff) begin
               plan    = append(plan, KIND_TEXT, req_ch);
               plan    = append(plan, KIND_END_OP, req_ch);
               mode_in = MODE_IDLE;
            end else begin
               plan = append(plan, KIND_END_OP, req_ch);
               plan = append(plan, st_plan.rec[0].kind, st_plan.rec[0].text_byte);
               if (st_plan.count == 2'd2) begin
                  plan = append(plan, st_plan.rec[1].kind, st_plan.rec[1].text_byte);
               end
               if (st_plan.count == 2'd0) begin
                  plan.count = 2'd1;
               end
               mode_in = st_mode;
               if (st_quote_we) quote_single_in = (req_ch == ChSquote);
               if (st_held_we)  held_op_in      = req_ch;
            end
         end
         MODE_QSTR: begin
            if (req_ch == ChNul) begin
               plan    = append(plan, KIND_ERROR, req_ch);
               mode_in = MODE_IDLE;
            end else if (req_ch == quote_ch) begin
               plan    = append(plan, KIND_END_WORD, req_ch);
               mode_in = MODE_IDLE;
            end else begin
               plan = append(plan, KIND_TEXT, req_ch);
            end
         end
         MODE_WORD: begin
            if (req_ch == ChNul || is_space || is_op) begin
               plan = append(plan, KIND_END_WORD, req_ch);
               plan = append(plan, st_plan.rec[0].kind, st_plan.rec[0].text_byte);
               if (st_plan.count == 2'd2) begin
                  plan = append(plan, st_plan.rec[1].kind, st_plan.rec[1].text_byte);
               end
               if (st_plan.count == 2'd0) begin
                  plan.count = 2'd1;
               end
               mode_in = st_mode;
               if (st_held_we) held_op_in = req_ch;
            end else begin
               if (is_quote) begin
                  quote_single_in = (req_ch == ChSquote);
                  mode_in         = MODE_WORDQ;
               end
               plan = append(plan, KIND_TEXT, req_ch);
            end
         end
         MODE_WORDQ: begin
            if (req_ch == ChNul) begin
               plan    = append(plan, KIND_ERROR, req_ch);
               mode_in = MODE_IDLE;
            end else begin
               if (req_ch == quote_ch) mode_in = MODE_WORD;
               plan = append(plan, KIND_TEXT, req_ch);
            end
         end
         MODE_DISCARD: begin
            if (req_ch == ChNul) mode_in = MODE_IDLE;
         end
         default: begin
            plan    = st_plan;
            mode_in = st_mode;
            if (st_quote_we) quote_single_in = (req_ch == ChSquote);
            if (st_held_we)  held_op_in      = req_ch;
         end
      endcase
   end

   assign q_push = accept && (plan.count != 2'd0);
   assign q_plan = plan;

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff         <= MODE_IDLE;
         quote_single_ff <= 1'b0;
         held_op_ff      <= 8'h00;
      end else if (accept) begin
         mode_ff         <= mode_in;
         quote_single_ff <= quote_single_in;
         held_op_ff      <= held_op_in;
      end
   end

endmodule

### src/stc_queue.sv
// Small FIFO of result plans between tokenizer front and back.
// Depends on stc_pkg.
module stc_queue (
   input  logic              clock,
   input  logic              reset,
   input  logic              push,
   input  stc_pkg::plan_type push_plan,
   output logic              full,
   input  logic              pop,
   output logic              not_empty,
   output stc_pkg::plan_type head
);
   import stc_pkg::*;

   plan_type         slot_ff [QDepth];
   logic [QAw-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [QAw-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [QAw:0]     count_ff, count_in;
   logic             do_push, do_pop;

   assign full      = (count_ff == (QAw+1)'(QDepth));
   assign not_empty = (count_ff != '0);
   assign head      = slot_ff[rd_ptr_ff];
   assign do_push   = push && !full;
   assign do_pop    = pop && not_empty;

   always_comb begin
      wr_ptr_in = do_push ? wr_ptr_ff + 1'b1 : wr_ptr_ff;
      rd_ptr_in = do_pop  ? rd_ptr_ff + 1'b1 : rd_ptr_ff;
      count_in  = count_ff;
      unique case ({do_push, do_pop})
         2'b10:   count_in = count_ff + 1'b1;
         2'b01:   count_in = count_ff - 1'b1;
         default: count_in = count_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) slot_ff[wr_ptr_ff] <= push_plan;
   end

endmodule

### src/stc_back.sv
// Tokenizer back: walks each queued plan and drives one result word per cycle while rsp_stall is low.
// Depends on stc_pkg.
module stc_back (
   input  logic              clock,
   input  logic              reset,
   input  logic              q_not_empty,
   input  stc_pkg::plan_type q_head,
   output logic              q_pop,
   output logic              rsp_valid,
   input  logic              rsp_stall,
   output logic [2:0]        rsp_kind,
   output logic [7:0]        rsp_text_byte,
   output logic              rsp_last
);
   import stc_pkg::*;

   logic       valid_ff, valid_in;
   logic [2:0] kind_ff;
   logic [7:0] byte_ff;
   logic       last_ff;
   logic [1:0] idx_ff, idx_in;
   logic       load, is_last;
   rec_type    cur;

   assign load    = q_not_empty && (!valid_ff || !rsp_stall);
   assign cur     = q_head.rec[idx_ff];
   assign is_last = (idx_ff == q_head.count - 2'd1);
   assign q_pop   = load && is_last;

   always_comb begin
      idx_in   = idx_ff;
      valid_in = valid_ff;
      if (load) begin
         idx_in   = is_last ? 2'd0 : idx_ff + 2'd1;
         valid_in = 1'b1;
      end else if (!rsp_stall) begin
         valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
         idx_ff   <= 2'd0;
      end else begin
         valid_ff <= valid_in;
         idx_ff   <= idx_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         kind_ff <= cur.kind;
         byte_ff <= cur.text_byte;
         last_ff <= is_last;
      end
   end

   assign rsp_valid     = valid_ff;
   assign rsp_kind      = kind_ff;
   assign rsp_text_byte = byte_ff;
   assign rsp_last      = last_ff;

endmodule

### src/shell_command_tokenizer.sv
// Shell command tokenizer top level: front, plan queue and back.
// Depends on stc_pkg, stc_front, stc_queue, stc_back.
//
//   channel  dir  handshake             payload
//   req      in   req_valid/req_stall   req_ch[7:0]
//   rsp      out  rsp_valid/rsp_stall   rsp_kind[2:0], rsp_text_byte[7:0], rsp_last
//
// A byte is taken every cycle while the four-entry plan queue has room.
// Each byte yields zero to three result words; the back drives one word
// per cycle while rsp_stall is low. A byte's first result word is held in
// the plan queue, then in the output register. Reset is synchronous and
// empties the queue; rsp_stall holds the output register and backs up the queue.
module shell_command_tokenizer (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_stall,
   input  logic [7:0] req_ch,
   output logic       rsp_valid,
   input  logic       rsp_stall,
   output logic [2:0] rsp_kind,
   output logic [7:0] rsp_text_byte,
   output logic       rsp_last
);
   import stc_pkg::*;

   logic     q_push, q_full, q_pop, q_not_empty;
   plan_type q_plan, q_head;

   stc_front u_front (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_ch    (req_ch),
      .q_full    (q_full),
      .q_push    (q_push),
      .q_plan    (q_plan)
   );

   stc_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (q_push),
      .push_plan (q_plan),
      .full      (q_full),
      .pop       (q_pop),
      .not_empty (q_not_empty),
      .head      (q_head)
   );

   stc_back u_back (
      .clock         (clock),
      .reset         (reset),
      .q_not_empty   (q_not_empty),
      .q_head        (q_head),
      .q_pop         (q_pop),
      .rsp_valid     (rsp_valid),
      .rsp_stall     (rsp_stall),
      .rsp_kind      (rsp_kind),
      .rsp_text_byte (rsp_text_byte),
      .rsp_last      (rsp_last)
   );

endmodule
